### hdl/stu_pkg.sv
// Shared types, token kind codes and byte classifiers for the source tokenizer.
// Used by stu_front, stu_queue, stu_back and source_tokenizer_unit; depends on nothing.

package stu_pkg;

    // Default geometry handed to the top level
    localparam int OFFSET_BITS_DEF = 32;
    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed field widths
    localparam int KIND_W      = 6;
    localparam int VAL_W       = 63;
    localparam int KW_MAX_LEN  = 8;
    localparam int KBUF_W      = 8 * KW_MAX_LEN;
    localparam int KW_COUNT    = 15;
    localparam int MAX_TOKENS  = 3;
    localparam int TCNT_W      = 2;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind K_IDENT   = 6'd0;
    localparam t_kind K_INT     = 6'd1;
    localparam t_kind K_FLOAT   = 6'd2;
    localparam t_kind K_STRING  = 6'd3;
    localparam t_kind K_KW0     = 6'd4;
    localparam t_kind K_PLUS    = 6'd19;
    localparam t_kind K_PLUS_EQ = 6'd20;
    localparam t_kind K_MINUS   = 6'd21;
    localparam t_kind K_MINUS_EQ = 6'd22;
    localparam t_kind K_ARROW   = 6'd23;
    localparam t_kind K_STAR    = 6'd24;
    localparam t_kind K_STAR_EQ = 6'd25;
    localparam t_kind K_SLASH   = 6'd26;
    localparam t_kind K_SLASH_EQ = 6'd27;
    localparam t_kind K_ASSIGN  = 6'd28;
    localparam t_kind K_EQ      = 6'd29;
    localparam t_kind K_BANG    = 6'd30;
    localparam t_kind K_NE      = 6'd31;
    localparam t_kind K_LT      = 6'd32;
    localparam t_kind K_LE      = 6'd33;
    localparam t_kind K_SHL     = 6'd34;
    localparam t_kind K_GT      = 6'd35;
    localparam t_kind K_GE      = 6'd36;
    localparam t_kind K_SHR     = 6'd37;
    localparam t_kind K_AMP     = 6'd38;
    localparam t_kind K_AND     = 6'd39;
    localparam t_kind K_PIPE    = 6'd40;
    localparam t_kind K_OR      = 6'd41;
    localparam t_kind K_LPAREN  = 6'd42;
    localparam t_kind K_RPAREN  = 6'd43;
    localparam t_kind K_LBRACE  = 6'd44;
    localparam t_kind K_RBRACE  = 6'd45;
    localparam t_kind K_LBRACK  = 6'd46;
    localparam t_kind K_RBRACK  = 6'd47;
    localparam t_kind K_SEMI    = 6'd48;
    localparam t_kind K_COMMA   = 6'd49;
    localparam t_kind K_DOT     = 6'd50;
    localparam t_kind K_COLON   = 6'd51;
    localparam t_kind K_SCOPE   = 6'd52;
    localparam t_kind K_PERCENT = 6'd53;
    localparam t_kind K_CARET   = 6'd54;
    localparam t_kind K_EOF     = 6'd55;
    localparam t_kind K_NONE    = 6'd0;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FRAC, M_EXP_MARK,
        M_EXP_DIGITS, M_STRING, M_STRING_ESC, M_OP, M_COMMENT
    } t_mode;

    function automatic logic is_num(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    // Kind of the one-byte operator, K_NONE when the byte is none
    function automatic t_kind op_single(logic [7:0] c);
        t_kind k;
        case (c)
            "+": k = K_PLUS;    "-": k = K_MINUS;   "*": k = K_STAR;
            "/": k = K_SLASH;   "=": k = K_ASSIGN;  "!": k = K_BANG;
            "<": k = K_LT;      ">": k = K_GT;      "&": k = K_AMP;
            "|": k = K_PIPE;    "(": k = K_LPAREN;  ")": k = K_RPAREN;
            "{": k = K_LBRACE;  "}": k = K_RBRACE;  "[": k = K_LBRACK;
            "]": k = K_RBRACK;  ";": k = K_SEMI;    ",": k = K_COMMA;
            ".": k = K_DOT;     ":": k = K_COLON;   "%": k = K_PERCENT;
            "^": k = K_CARET;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // Operators that may grow into a two-byte form
    function automatic logic op_waits(logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "=") ||
               (c == "!") || (c == "<") || (c == ">") || (c == "&") || (c == "|") ||
               (c == ":");
    endfunction

    function automatic t_kind op_pair(logic [7:0] a, logic [7:0] b);
        t_kind k;
        k = K_NONE;
        if (b == "=") begin
            case (a)
                "+": k = K_PLUS_EQ;  "-": k = K_MINUS_EQ; "*": k = K_STAR_EQ;
                "/": k = K_SLASH_EQ; "=": k = K_EQ;       "!": k = K_NE;
                "<": k = K_LE;       ">": k = K_GE;
                default: k = K_NONE;
            endcase
        end
        if (a == "-" && b == ">") k = K_ARROW;
        if (a == "<" && b == "<") k = K_SHL;
        if (a == ">" && b == ">") k = K_SHR;
        if (a == "&" && b == "&") k = K_AND;
        if (a == "|" && b == "|") k = K_OR;
        if (a == ":" && b == ":") k = K_SCOPE;
        return k;
    endfunction

    // Keyword text, right-aligned with the first character highest
    function automatic logic [KBUF_W-1:0] kw_text(int i);
        logic [KBUF_W-1:0] t;
        case (i)
            0: t = "fn";      1: t = "if";      2: t = "else";    3: t = "while";
            4: t = "for";     5: t = "break";   6: t = "continue"; 7: t = "return";
            8: t = "struct";  9: t = "enum";    10: t = "const";  11: t = "use";
            12: t = "print";  13: t = "true";   14: t = "false";
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic int kw_len(int i);
        int n;
        case (i)
            0, 1: n = 2;
            4, 11: n = 3;
            2, 9, 13: n = 4;
            3, 5, 10, 12, 14: n = 5;
            7, 8: n = 6;
            6: n = 8;
            default: n = 0;
        endcase
        return n;
    endfunction

    // Keyword packed with its first character in the lowest byte
    function automatic logic [KBUF_W-1:0] kw_packed(int i);
        logic [KBUF_W-1:0] t;
        logic [KBUF_W-1:0] p;
        int n;
        t = kw_text(i);
        n = kw_len(i);
        p = '0;
        for (int j = 0; j < KW_MAX_LEN; j++) begin
            if (j < n) p[8*j +: 8] = t[8*(n-1-j) +: 8];
        end
        return p;
    endfunction

    // Keyword kind for a short word, K_IDENT when it is no keyword
    function automatic t_kind kw_kind(logic [KBUF_W-1:0] kb, logic [3:0] len);
        t_kind k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if ((int'(len) == kw_len(i)) && (kb == kw_packed(i)))
                k = K_KW0 + t_kind'(i);
        end
        return k;
    endfunction

endpackage

### hdl/stu_front.sv
// Scanner front end: accepts bytes, tracks position and builds token bundles.
// Depends on stu_pkg; feeds stu_queue.

module stu_front import stu_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int TOK_W       = KIND_W + 2*OFFSET_BITS + LINE_BITS
                                + COLUMN_BITS + VAL_W + KBUF_W,
    parameter int BUN_W       = TCNT_W + MAX_TOKENS*TOK_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_eoi,
    output logic             o_push,
    input  logic             i_room,
    output logic [BUN_W-1:0] o_bundle
);

    localparam int OB = OFFSET_BITS;
    localparam int LB = LINE_BITS;
    localparam int CB = COLUMN_BITS;

    t_mode               r_mode, n_mode;
    logic [7:0]          r_pend, n_pend;
    logic [7:0]          r_quote, n_quote;
    logic [KBUF_W-1:0]   r_kbuf, n_kbuf;
    logic [OB-1:0]       r_tstart, n_tstart;
    logic [LB-1:0]       r_tline, n_tline;
    logic [CB-1:0]       r_tcol, n_tcol;
    logic [VAL_W-1:0]    r_acc, n_acc;
    logic [OB-1:0]       r_off, n_off;
    logic [LB-1:0]       r_line, n_line;
    logic [CB-1:0]       r_col, n_col;
    logic [CB-1:0]       r_dcol, n_dcol;

    logic [TOK_W-1:0]    w_tk [MAX_TOKENS];
    logic [TCNT_W-1:0]   w_cnt;
    logic                w_used;
    logic                w_acc_en;
    logic [OB-1:0]       w_len;
    logic [OB-1:0]       w_dot_off;
    logic [CB-1:0]       w_col_inc;
    logic [VAL_W+3:0]    w_mul;

    function automatic logic [TOK_W-1:0] mk(t_kind k, logic [OB-1:0] s, logic [OB-1:0] l,
                                            logic [LB-1:0] ln, logic [CB-1:0] c,
                                            logic [VAL_W-1:0] v, logic [KBUF_W-1:0] kb);
        return {kb, v, c, ln, l, s, k};
    endfunction

    assign o_ready   = i_room;
    assign w_acc_en  = i_valid && i_room;
    assign w_len     = r_off - r_tstart;
    assign w_dot_off = r_off - OB'(1);
    assign w_col_inc = (r_col == '1) ? r_col : r_col + CB'(1);
    // Ten times the accumulator plus the digit, wide enough to spot overflow
    assign w_mul     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                       + (VAL_W+4)'(i_byte - 8'h30);

    // Scan one byte or flush at end of input
    always_comb begin
        n_mode = r_mode;   n_pend = r_pend;   n_quote = r_quote; n_kbuf = r_kbuf;
        n_tstart = r_tstart; n_tline = r_tline; n_tcol = r_tcol;  n_acc = r_acc;
        n_off = r_off;     n_line = r_line;   n_col = r_col;     n_dcol = r_dcol;
        for (int i = 0; i < MAX_TOKENS; i++) w_tk[i] = '0;
        w_cnt  = '0;
        w_used = 1'b1;
        if (i_eoi) begin
            // Flush the pending token, then close with end-of-file
            case (r_mode)
                M_IDENT: begin
                    w_tk[w_cnt] = mk(K_IDENT, r_tstart, w_len, r_tline, r_tcol, '0, r_kbuf);
                    w_cnt = w_cnt + 2'd1;
                end
                M_INT: begin
                    w_tk[w_cnt] = mk(K_INT, r_tstart, w_len, r_tline, r_tcol, r_acc, '0);
                    w_cnt = w_cnt + 2'd1;
                end
                M_INT_DOT: begin
                    w_tk[w_cnt] = mk(K_INT, r_tstart, w_dot_off - r_tstart, r_tline, r_tcol,
                                     r_acc, '0);
                    w_cnt = w_cnt + 2'd1;
                    w_tk[w_cnt] = mk(K_DOT, w_dot_off, OB'(1), r_line, r_dcol, '0, '0);
                    w_cnt = w_cnt + 2'd1;
                end
                M_FRAC, M_EXP_MARK, M_EXP_DIGITS: begin
                    w_tk[w_cnt] = mk(K_FLOAT, r_tstart, w_len, r_tline, r_tcol, '0, '0);
                    w_cnt = w_cnt + 2'd1;
                end
                M_STRING, M_STRING_ESC: begin
                    w_tk[w_cnt] = mk(K_STRING, r_tstart, w_len, r_tline, r_tcol, '0, '0);
                    w_cnt = w_cnt + 2'd1;
                end
                M_OP: begin
                    w_tk[w_cnt] = mk(op_single(r_pend), r_tstart, OB'(1), r_tline, r_tcol,
                                     '0, '0);
                    w_cnt = w_cnt + 2'd1;
                end
                default: ;
            endcase
            w_tk[w_cnt] = mk(K_EOF, r_off, '0, r_line, r_col, '0, '0);
            w_cnt = w_cnt + 2'd1;
            // Return to the reset state for the next text
            n_mode = M_IDLE;  n_pend = '0;  n_quote = '0;  n_kbuf = '0;
            n_tstart = '0;    n_tline = LB'(1); n_tcol = CB'(1); n_acc = '0;
            n_off = '0;       n_line = LB'(1);  n_col = CB'(1);  n_dcol = CB'(1);
        end else begin
            // Continue the token in progress
            case (r_mode)
                M_IDENT: begin
                    if (is_letter(i_byte) || is_num(i_byte)) begin
                        if (w_len[OB-1:3] == '0) n_kbuf[{w_len[2:0], 3'b000} +: 8] = i_byte;
                    end else begin
                        w_tk[w_cnt] = mk(K_IDENT, r_tstart, w_len, r_tline, r_tcol, '0, r_kbuf);
                        w_cnt = w_cnt + 2'd1;
                        w_used = 1'b0;
                    end
                end
                M_INT: begin
                    if (is_num(i_byte)) begin
                        n_acc = (w_mul[VAL_W+3:VAL_W] != '0) ? '1 : w_mul[VAL_W-1:0];
                    end else if (i_byte == ".") begin
                        n_dcol = r_col;
                        n_mode = M_INT_DOT;
                    end else if (i_byte == "e" || i_byte == "E") begin
                        n_mode = M_EXP_MARK;
                    end else begin
                        w_tk[w_cnt] = mk(K_INT, r_tstart, w_len, r_tline, r_tcol, r_acc, '0);
                        w_cnt = w_cnt + 2'd1;
                        w_used = 1'b0;
                    end
                end
                M_INT_DOT: begin
                    if (is_num(i_byte)) begin
                        n_mode = M_FRAC;
                    end else begin
                        w_tk[w_cnt] = mk(K_INT, r_tstart, w_dot_off - r_tstart, r_tline,
                                         r_tcol, r_acc, '0);
                        w_cnt = w_cnt + 2'd1;
                        w_tk[w_cnt] = mk(K_DOT, w_dot_off, OB'(1), r_line, r_dcol, '0, '0);
                        w_cnt = w_cnt + 2'd1;
                        w_used = 1'b0;
                    end
                end
                M_FRAC: begin
                    if (i_byte == "e" || i_byte == "E") begin
                        n_mode = M_EXP_MARK;
                    end else if (!is_num(i_byte)) begin
                        w_tk[w_cnt] = mk(K_FLOAT, r_tstart, w_len, r_tline, r_tcol, '0, '0);
                        w_cnt = w_cnt + 2'd1;
                        w_used = 1'b0;
                    end
                end
                M_EXP_MARK: begin
                    if (i_byte == "+" || i_byte == "-" || is_num(i_byte)) begin
                        n_mode = M_EXP_DIGITS;
                    end else begin
                        w_tk[w_cnt] = mk(K_FLOAT, r_tstart, w_len, r_tline, r_tcol, '0, '0);
                        w_cnt = w_cnt + 2'd1;
                        w_used = 1'b0;
                    end
                end
                M_EXP_DIGITS: begin
                    if (!is_num(i_byte)) begin
                        w_tk[w_cnt] = mk(K_FLOAT, r_tstart, w_len, r_tline, r_tcol, '0, '0);
                        w_cnt = w_cnt + 2'd1;
                        w_used = 1'b0;
                    end
                end
                M_STRING: begin
                    if (i_byte == r_quote) begin
                        w_tk[w_cnt] = mk(K_STRING, r_tstart, w_len, r_tline, r_tcol, '0, '0);
                        w_cnt = w_cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else if (i_byte == 8'h5C) begin
                        n_mode = M_STRING_ESC;
                    end
                end
                M_STRING_ESC: n_mode = M_STRING;
                M_OP: begin
                    if (r_pend == "/" && i_byte == "/") begin
                        n_mode = M_COMMENT;
                    end else if (op_pair(r_pend, i_byte) != K_NONE) begin
                        w_tk[w_cnt] = mk(op_pair(r_pend, i_byte), r_tstart, OB'(2), r_tline,
                                         r_tcol, '0, '0);
                        w_cnt = w_cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        w_tk[w_cnt] = mk(op_single(r_pend), r_tstart, OB'(1), r_tline,
                                         r_tcol, '0, '0);
                        w_cnt = w_cnt + 2'd1;
                        w_used = 1'b0;
                    end
                end
                M_COMMENT: begin
                    if (i_byte == 8'h0A) w_used = 1'b0;
                end
                default: ;
            endcase
            // Start a new token from idle, or from a byte the old token left over
            if (r_mode == M_IDLE || !w_used) begin
                n_mode = M_IDLE;
                if (is_blank(i_byte)) begin
                    n_mode = M_IDLE;
                end else if (is_num(i_byte)) begin
                    n_tstart = r_off; n_tline = r_line; n_tcol = r_col;
                    n_acc = VAL_W'(i_byte - 8'h30);
                    n_mode = M_INT;
                end else if (i_byte == 8'h22 || i_byte == 8'h27) begin
                    n_quote = i_byte;
                    n_tstart = r_off + OB'(1); n_tline = r_line; n_tcol = w_col_inc;
                    n_mode = M_STRING;
                end else if (is_letter(i_byte)) begin
                    n_tstart = r_off; n_tline = r_line; n_tcol = r_col;
                    n_kbuf = KBUF_W'(i_byte);
                    n_mode = M_IDENT;
                end else if (op_waits(i_byte)) begin
                    n_tstart = r_off; n_tline = r_line; n_tcol = r_col;
                    n_pend = i_byte;
                    n_mode = M_OP;
                end else if (op_single(i_byte) != K_NONE) begin
                    w_tk[w_cnt] = mk(op_single(i_byte), r_off, OB'(1), r_line, r_col, '0, '0);
                    w_cnt = w_cnt + 2'd1;
                end
            end
            // Advance the position
            if (i_byte == 8'h0A) begin
                n_line = (r_line == '1) ? r_line : r_line + LB'(1);
                n_col  = CB'(1);
            end else begin
                n_col  = w_col_inc;
            end
            n_off = r_off + OB'(1);
        end
    end

    assign o_push   = w_acc_en && (w_cnt != '0);
    assign o_bundle = {w_cnt, w_tk[2], w_tk[1], w_tk[0]};

    // Hold scanner state until a byte is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;  r_pend <= '0;  r_quote <= '0;  r_kbuf <= '0;
            r_tstart <= '0;    r_tline <= LB'(1); r_tcol <= CB'(1); r_acc <= '0;
            r_off <= '0;       r_line <= LB'(1);  r_col <= CB'(1);  r_dcol <= CB'(1);
        end else if (w_acc_en) begin
            r_mode <= n_mode;  r_pend <= n_pend;  r_quote <= n_quote; r_kbuf <= n_kbuf;
            r_tstart <= n_tstart; r_tline <= n_tline; r_tcol <= n_tcol; r_acc <= n_acc;
            r_off <= n_off;    r_line <= n_line;  r_col <= n_col;    r_dcol <= n_dcol;
        end
    end

endmodule

### hdl/stu_queue.sv
// Short FIFO of token bundles between the scanner and the emitter.
// Depends on stu_pkg for default sizes only.

module stu_queue import stu_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_room,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_room  = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // Store a bundle at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

### hdl/stu_back.sv
// Emitter back end: walks each bundle, resolves keywords, drives the output register.
// Depends on stu_pkg; reads from stu_queue.

module stu_back import stu_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int TOK_W       = KIND_W + 2*OFFSET_BITS + LINE_BITS
                                + COLUMN_BITS + VAL_W + KBUF_W,
    parameter int BUN_W       = TCNT_W + MAX_TOKENS*TOK_W,
    parameter int DATA_W      = 168
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BUN_W-1:0]  i_bundle,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [DATA_W-1:0] o_tdata,
    output logic [KIND_W-1:0] o_tuser,
    output logic              o_tlast
);

    localparam int OB = OFFSET_BITS;
    localparam int LB = LINE_BITS;
    localparam int CB = COLUMN_BITS;

    logic [TCNT_W-1:0] r_idx;
    logic [TCNT_W-1:0] w_cnt;
    logic [TOK_W-1:0]  w_tok;
    t_kind             w_kind;
    logic [OB-1:0]     w_start, w_len;
    logic [LB-1:0]     w_line;
    logic [CB-1:0]     w_col;
    logic [VAL_W-1:0]  w_val;
    logic [KBUF_W-1:0] w_kb;
    t_kind             w_kind_out;
    logic              w_last, w_load;

    logic              r_tvalid;
    logic [DATA_W-1:0] r_tdata;
    t_kind             r_tuser;
    logic              r_tlast;

    // Pick the current token of the head bundle
    assign w_cnt = i_bundle[BUN_W-1 -: TCNT_W];
    assign w_tok = i_bundle[r_idx*TOK_W +: TOK_W];
    assign {w_kb, w_val, w_col, w_line, w_len, w_start, w_kind} = w_tok;

    // Turn short words into keywords
    always_comb begin
        w_kind_out = w_kind;
        if (w_kind == K_IDENT && w_len[OB-1:4] == '0 && w_len[3:0] <= 4'(KW_MAX_LEN))
            w_kind_out = kw_kind(w_kb, w_len[3:0]);
    end

    assign w_last = (r_idx == w_cnt - TCNT_W'(1));
    assign w_load = i_valid && (!r_tvalid || i_tready);
    assign o_pop  = w_load && w_last;

    // Step through the bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)    r_idx <= '0;
        else if (w_load) r_idx <= w_last ? '0 : r_idx + TCNT_W'(1);
    end

    // Output register: load when empty or when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_tvalid <= 1'b0;
        else if (w_load)   r_tvalid <= 1'b1;
        else if (i_tready) r_tvalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tdata <= DATA_W'({w_val, w_col, w_line, w_len, w_start});
            r_tuser <= w_kind_out;
            r_tlast <= w_last;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

endmodule

### hdl/source_tokenizer_unit.sv
// Top level of the source tokenizer: scanner, bundle queue and emitter.
// Depends on stu_pkg, stu_front, stu_queue and stu_back.
//
//  Channel  Dir  Handshake              Payload
//  s        in   i_s_tvalid/o_s_tready  tdata: text_byte; tuser: end_of_input
//  m        out  o_m_tvalid/i_m_tready  tdata: offset,length,line,column,value
//                                       tuser: token_kind; tlast: last_of_run
//
// One byte is taken every cycle while the bundle queue has room; the scanner
// does all per-byte work combinationally and writes up to three tokens at once.
// The emitter sends one token per cycle from its output register while the
// output is ready, so a byte that yields several tokens leaves as several beats.
// Reset is synchronous and active low and clears all control state.
// A stall on the output fills the queue; the input then stalls until it drains.

module source_tokenizer_unit import stu_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] text_byte
    input  logic              i_s_tuser,   // [0] end_of_input
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // from bit 0: token offset, lexeme length, line, column, integer value
    output logic [((2*OFFSET_BITS+LINE_BITS+COLUMN_BITS+VAL_W+7)/8)*8-1:0] o_m_tdata,
    output logic [KIND_W-1:0] o_m_tuser,   // [5:0] token_kind
    output logic              o_m_tlast    // last_of_run
);

    localparam int TOK_W  = KIND_W + 2*OFFSET_BITS + LINE_BITS + COLUMN_BITS + VAL_W + KBUF_W;
    localparam int BUN_W  = TCNT_W + MAX_TOKENS*TOK_W;
    localparam int DATA_W = ((2*OFFSET_BITS + LINE_BITS + COLUMN_BITS + VAL_W + 7)/8)*8;
    localparam int VAL_LO = 2*OFFSET_BITS + LINE_BITS + COLUMN_BITS;

    logic             w_push, w_room, w_pop, w_qvalid;
    logic [BUN_W-1:0] w_bun_in, w_bun_out;

    stu_front #(
        .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS),
        .TOK_W(TOK_W), .BUN_W(BUN_W)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid), .o_ready(o_s_tready),
        .i_byte(i_s_tdata), .i_eoi(i_s_tuser),
        .o_push(w_push), .i_room(w_room), .o_bundle(w_bun_in)
    );

    stu_queue #(.WIDTH(BUN_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_data(w_bun_in), .o_room(w_room),
        .i_pop(w_pop), .o_valid(w_qvalid), .o_data(w_bun_out)
    );

    stu_back #(
        .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS),
        .TOK_W(TOK_W), .BUN_W(BUN_W), .DATA_W(DATA_W)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qvalid), .i_bundle(w_bun_out), .o_pop(w_pop),
        .o_tvalid(o_m_tvalid), .i_tready(i_m_tready),
        .o_tdata(o_m_tdata), .o_tuser(o_m_tuser), .o_tlast(o_m_tlast)
    );

    // End-of-file always closes its run
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == K_EOF) |-> o_m_tlast)
        else $error("end-of-file token not marked last");

    // No kind beyond end-of-file is ever produced
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= K_EOF))
        else $error("token kind out of range");

    // Only integer tokens carry a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != K_INT) |-> (o_m_tdata[VAL_LO +: VAL_W] == '0))
        else $error("value on a non-integer token");

    // A stalled front never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_room)
        else $error("bundle queue overflow");

endmodule
